// ----- sv/dvss_pkg.sv -----
package dvss_pkg;

  localparam int FrameW    = 20;
  localparam int TcW       = 22;
  localparam int DateW     = 32;
  localparam int ErrW      = 12;
  localparam int ClipW     = 8;
  localparam int HoursW    = 5;
  localparam int MinutesW  = 6;
  localparam int SecondsW  = 6;
  localparam int FramesW   = 5;
  localparam int CfgDataW  = 8;
  localparam int CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] CFG_SKIP_DATE = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_CLIP_ID   = 1'd1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [FrameW-1:0]   frame_index;
    logic                timecode_valid;
    logic [HoursW-1:0]   tc_hours;
    logic [MinutesW-1:0] tc_minutes;
    logic [SecondsW-1:0] tc_seconds;
    logic [FramesW-1:0]  tc_frames;
    logic                date_valid;
    logic [DateW-1:0]    record_date;
    logic [ErrW-1:0]     error_blocks;
  } item_t;

  typedef struct packed {
    logic [ClipW-1:0]  seg_clip;
    logic [FrameW-1:0] first_frame;
    logic [FrameW-1:0] last_frame;
    logic [TcW-1:0]    first_timecode;
    logic [TcW-1:0]    last_timecode;
    logic [DateW-1:0]  first_date;
    logic [DateW-1:0]  last_date;
    logic [ErrW-1:0]   seg_errors;
  } result_t;

endpackage

// ----- sv/dvss_tc_count.sv -----
module dvss_tc_count (
  input  logic [dvss_pkg::HoursW-1:0]   tc_hours,
  input  logic [dvss_pkg::MinutesW-1:0] tc_minutes,
  input  logic [dvss_pkg::SecondsW-1:0] tc_seconds,
  input  logic [dvss_pkg::FramesW-1:0]  tc_frames,
  output logic [dvss_pkg::TcW-1:0]      count
);
  import dvss_pkg::*;

  logic [10:0] hm;
  logic [16:0] hms;

  assign hm    = 11'(tc_hours) * 11'd60 + 11'(tc_minutes);
  assign hms   = 17'(hm) * 17'd60 + 17'(tc_seconds);
  assign count = TcW'(hms) * TcW'(25) + TcW'(tc_frames);

endmodule

// ----- sv/dvss_track.sv -----
module dvss_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  dvss_pkg::item_t              item,
  input  logic                         skip_date,
  input  logic [dvss_pkg::ClipW-1:0]   clip_id,
  output logic                         emit,
  output dvss_pkg::result_t            result
);
  import dvss_pkg::*;

  logic              segment_open;
  logic [FrameW-1:0] start_frame;
  logic [TcW-1:0]    start_timecode;
  logic [DateW-1:0]  start_date;
  logic [ErrW-1:0]   open_errors;
  logic [TcW-1:0]    prior_timecode;
  logic [DateW-1:0]  prior_date;

  logic [TcW-1:0]    tc_raw;
  logic [TcW-1:0]    tc;
  logic [DateW-1:0]  date;
  logic [TcW:0]      prior_plus;
  logic              is_end;
  logic              date_ok;
  logic              fill;
  logic              cut;
  logic              start_new;
  logic [TcW-1:0]    tc_next;
  logic [DateW-1:0]  date_next;

  dvss_tc_count u_tc (
    .tc_hours   (item.tc_hours),
    .tc_minutes (item.tc_minutes),
    .tc_seconds (item.tc_seconds),
    .tc_frames  (item.tc_frames),
    .count      (tc_raw)
  );

  always_comb begin
    is_end     = (item.kind == KIND_END);
    tc         = item.timecode_valid ? tc_raw : '0;
    date       = item.date_valid ? item.record_date : '0;
    date_ok    = item.date_valid | skip_date;
    prior_plus = {1'b0, prior_timecode} + (TcW+1)'(1);
    cut = segment_open && (!item.timecode_valid || !date_ok ||
                           ({1'b0, tc} != prior_plus) || (date != prior_date) ||
                           (item.error_blocks != open_errors));
    emit      = is_end ? segment_open : cut;
    start_new = !segment_open || cut;
    fill      = !skip_date && (!item.timecode_valid || !item.date_valid);
    tc_next   = (fill || !item.timecode_valid) ? prior_plus[TcW-1:0] : tc;
    date_next = fill ? prior_date : date;

    result.seg_clip       = clip_id;
    result.first_frame    = start_frame;
    result.last_frame     = item.frame_index - FrameW'(1);
    result.first_timecode = start_timecode;
    result.last_timecode  = prior_timecode;
    result.first_date     = start_date;
    result.last_date      = prior_date;
    result.seg_errors     = open_errors;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_open   <= 1'b0;
      start_frame    <= '0;
      start_timecode <= '0;
      start_date     <= '0;
      open_errors    <= '0;
      prior_timecode <= '0;
      prior_date     <= '0;
    end else if (fire) begin
      if (is_end) begin
        segment_open   <= 1'b0;
        start_frame    <= '0;
        start_timecode <= '0;
        start_date     <= '0;
        open_errors    <= '0;
        prior_timecode <= '0;
        prior_date     <= '0;
      end else begin
        segment_open   <= 1'b1;
        prior_timecode <= tc_next;
        prior_date     <= date_next;
        if (start_new) begin
          start_frame    <= item.frame_index;
          start_timecode <= tc_next;
          start_date     <= date_next;
          open_errors    <= item.error_blocks;
        end
      end
    end
  end

  a_emit_needs_open: assert property (@(posedge clk) disable iff (rst)
    fire && emit |-> segment_open)
    else $error("segment emitted with none open");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && is_end |=> !segment_open && prior_timecode == '0)
    else $error("end beat left state behind");

  a_frame_opens: assert property (@(posedge clk) disable iff (rst)
    fire && !is_end |=> segment_open)
    else $error("frame beat left no open segment");

  a_tc_tracks: assert property (@(posedge clk) disable iff (rst)
    fire && !is_end && item.timecode_valid && (skip_date || item.date_valid)
    |=> prior_timecode == $past(tc_raw))
    else $error("prior timecode does not follow frame");

endmodule

// ----- sv/dv_frame_scene_segmenter.sv -----
// Splits a DV clip into segments of frames with continuous timecode, one
// recording date and one error-block count, one frame-metadata beat at a
// time, and reports each finished segment as one output beat. A beat is
// taken into an input register and decided against the segment state once
// the output register is free, and a segment that the beat closes is then
// registered for output. With out_ready high a new beat is taken every cycle;
// while a finished segment waits for out_ready the decision stage holds its
// beat and in_ready drops. The rate is set by the single compare-and-update
// step on the segment state. Write skip_date and clip_id only while no beat
// is in flight.
module dv_frame_scene_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dvss_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [dvss_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [dvss_pkg::FrameW-1:0]     frame_index,
  input  logic                            timecode_valid,
  input  logic [dvss_pkg::HoursW-1:0]     tc_hours,
  input  logic [dvss_pkg::MinutesW-1:0]   tc_minutes,
  input  logic [dvss_pkg::SecondsW-1:0]   tc_seconds,
  input  logic [dvss_pkg::FramesW-1:0]    tc_frames,
  input  logic                            date_valid,
  input  logic [dvss_pkg::DateW-1:0]      record_date,
  input  logic [dvss_pkg::ErrW-1:0]       error_blocks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dvss_pkg::ClipW-1:0]      seg_clip,
  output logic [dvss_pkg::FrameW-1:0]     first_frame,
  output logic [dvss_pkg::FrameW-1:0]     last_frame,
  output logic [dvss_pkg::TcW-1:0]        first_timecode,
  output logic [dvss_pkg::TcW-1:0]        last_timecode,
  output logic [dvss_pkg::DateW-1:0]      first_date,
  output logic [dvss_pkg::DateW-1:0]      last_date,
  output logic [dvss_pkg::ErrW-1:0]       seg_errors
);
  import dvss_pkg::*;

  logic             skip_date;
  logic [ClipW-1:0] clip_id;
  logic             item_valid;
  item_t            item;
  logic             fire;
  logic             emit;
  result_t          result;
  result_t          out_reg;

  assign fire     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_date <= 1'b0;
      clip_id   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP_DATE: skip_date <= cfg_data[0];
        CFG_CLIP_ID:   clip_id   <= cfg_data[ClipW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.kind           <= kind;
      item.frame_index    <= frame_index;
      item.timecode_valid <= timecode_valid;
      item.tc_hours       <= tc_hours;
      item.tc_minutes     <= tc_minutes;
      item.tc_seconds     <= tc_seconds;
      item.tc_frames      <= tc_frames;
      item.date_valid     <= date_valid;
      item.record_date    <= record_date;
      item.error_blocks   <= error_blocks;
    end
  end

  dvss_track u_track (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .skip_date (skip_date),
    .clip_id   (clip_id),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_reg <= result;
    end
  end

  assign seg_clip       = out_reg.seg_clip;
  assign first_frame    = out_reg.first_frame;
  assign last_frame     = out_reg.last_frame;
  assign first_timecode = out_reg.first_timecode;
  assign last_timecode  = out_reg.last_timecode;
  assign first_date     = out_reg.first_date;
  assign last_date      = out_reg.last_date;
  assign seg_errors     = out_reg.seg_errors;

endmodule

// ----- tb/sv/tb_dv_frame_scene_segmenter.sv -----
module tb_dv_frame_scene_segmenter;
  timeunit 1ns;
  timeprecision 1ps;

  import dvss_pkg::*;

  localparam int unsigned TcDay = 24 * 60 * 60 * 25;
  localparam int IdleLimit = 5000;
  localparam int LongStall = 400;
  localparam int Settle = 8;

  typedef struct packed {
    logic             open;
    logic [FrameW-1:0] first_frame;
    logic [TcW-1:0]    first_tc;
    logic [DateW-1:0]  first_date;
    logic [ErrW-1:0]   errs;
    logic [TcW-1:0]    prev_tc;
    logic [DateW-1:0]  prev_date;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t cur_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ClipW-1:0] seg_clip;
  logic [FrameW-1:0] first_frame;
  logic [FrameW-1:0] last_frame;
  logic [TcW-1:0] first_timecode;
  logic [TcW-1:0] last_timecode;
  logic [DateW-1:0] first_date;
  logic [DateW-1:0] last_date;
  logic [ErrW-1:0] seg_errors;

  item_t frame_beats[$];
  result_t segments_due[$];
  segment_t cur_seg = '0;
  logic skip_date_reg = 1'b0;
  logic [ClipW-1:0] clip_reg = '0;

  logic in_fire = 1'b0;
  int n_errors = 0;
  int idle_cycles = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int stall_ticket = 0;
  int stall_seen = 0;
  bit steady = 1'b0;

  int unsigned gen_idx;
  int unsigned gen_tc;
  int unsigned gen_date;
  int unsigned gen_errs;
  bit gen_nodate;

  dv_frame_scene_segmenter uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(cur_item.kind),
    .frame_index(cur_item.frame_index),
    .timecode_valid(cur_item.timecode_valid),
    .tc_hours(cur_item.tc_hours),
    .tc_minutes(cur_item.tc_minutes),
    .tc_seconds(cur_item.tc_seconds),
    .tc_frames(cur_item.tc_frames),
    .date_valid(cur_item.date_valid),
    .record_date(cur_item.record_date),
    .error_blocks(cur_item.error_blocks),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .seg_clip(seg_clip),
    .first_frame(first_frame),
    .last_frame(last_frame),
    .first_timecode(first_timecode),
    .last_timecode(last_timecode),
    .first_date(first_date),
    .last_date(last_date),
    .seg_errors(seg_errors)
  );

  always #5 clk = ~clk;

  function automatic int random_gap();
    int unsigned r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_beat(item_t it);
    frame_beats.insert(frame_beats.size(), it);
  endfunction

  function automatic void track_segment(item_t it);
    logic [TcW-1:0] tc;
    logic [DateW-1:0] date;
    logic tc_ok;
    logic date_ok;
    result_t seg_out;
    tc_ok = it.timecode_valid;
    date_ok = it.date_valid;
    seg_out.seg_clip = clip_reg;
    seg_out.first_frame = cur_seg.first_frame;
    seg_out.last_frame = it.frame_index - FrameW'(1);
    seg_out.first_timecode = cur_seg.first_tc;
    seg_out.last_timecode = cur_seg.prev_tc;
    seg_out.first_date = cur_seg.first_date;
    seg_out.last_date = cur_seg.prev_date;
    seg_out.seg_errors = cur_seg.errs;
    if (it.kind == KIND_END) begin
      if (cur_seg.open) segments_due.insert(segments_due.size(), seg_out);
      cur_seg = '0;
    end else begin
      tc = tc_ok ? TcW'(((32'(it.tc_hours) * 60 + 32'(it.tc_minutes)) * 60
                         + 32'(it.tc_seconds)) * 25 + 32'(it.tc_frames)) : '0;
      date = date_ok ? it.record_date : '0;
      if (skip_date_reg) date_ok = 1'b1;
      if (cur_seg.open && (!tc_ok || !date_ok || 32'(tc) != 32'(cur_seg.prev_tc) + 1
                           || date != cur_seg.prev_date
                           || it.error_blocks != cur_seg.errs)) begin
        segments_due.insert(segments_due.size(), seg_out);
        cur_seg.open = 1'b0;
      end
      if (!tc_ok || !date_ok) begin
        tc = cur_seg.prev_tc + TcW'(1);
        if (!skip_date_reg) date = cur_seg.prev_date;
      end
      if (!cur_seg.open) begin
        cur_seg.open = 1'b1;
        cur_seg.first_frame = it.frame_index;
        cur_seg.errs = it.error_blocks;
        cur_seg.first_tc = tc;
        cur_seg.first_date = date;
      end
      cur_seg.prev_tc = tc;
      cur_seg.prev_date = date;
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) track_segment(cur_item);
    if (!rst && out_valid && out_ready) begin
      if (segments_due.size() == 0) begin
        $error("segment beat with nothing pending: first_frame 0x%0h", first_frame);
        n_errors++;
      end else begin
        want = segments_due.pop_front();
        check_field("seg_clip", want.seg_clip, seg_clip);
        check_field("first_frame", want.first_frame, first_frame);
        check_field("last_frame", want.last_frame, last_frame);
        check_field("first_timecode", want.first_timecode, first_timecode);
        check_field("last_timecode", want.last_timecode, last_timecode);
        check_field("first_date", want.first_date, first_date);
        check_field("last_date", want.last_date, last_date);
        check_field("seg_errors", want.seg_errors, seg_errors);
      end
    end
    if (in_fire || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold the beat until taken, then idle for a random gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (frame_beats.size() > 0) begin
      cur_item <= frame_beats.pop_front();
      in_valid <= 1'b1;
      tx_gap = random_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_seen != stall_ticket) begin
      stall_seen = stall_ticket;
      rx_wait = LongStall;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_wait = random_gap();
    end
  end

  function automatic item_t frame_at(int unsigned count);
    item_t it = '0;
    it.kind = KIND_FRAME;
    it.timecode_valid = 1'b1;
    it.tc_frames = FramesW'(count % 25);
    it.tc_seconds = SecondsW'((count / 25) % 60);
    it.tc_minutes = MinutesW'((count / 1500) % 60);
    it.tc_hours = HoursW'(count / 90000);
    it.date_valid = 1'b1;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.kind = KIND_FRAME;
    it.frame_index = FrameW'($urandom);
    it.timecode_valid = 1'($urandom);
    it.tc_hours = HoursW'($urandom);
    it.tc_minutes = MinutesW'($urandom);
    it.tc_seconds = SecondsW'($urandom);
    it.tc_frames = FramesW'($urandom);
    it.date_valid = 1'($urandom);
    it.record_date = $urandom;
    it.error_blocks = ErrW'($urandom);
    return it;
  endfunction

  function automatic void new_take();
    gen_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(1048000, 1048575)
                                           : $urandom_range(0, 5000);
    gen_tc = ($urandom_range(0, 4) == 0) ? TcDay - $urandom_range(1, 30)
                                         : $urandom_range(0, TcDay - 1);
    gen_date = $urandom;
    gen_errs = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
    gen_nodate = ($urandom_range(0, 3) == 0);
  endfunction

  function automatic item_t next_random_item();
    item_t it;
    int unsigned r = $urandom_range(0, 999);
    int unsigned p = $urandom_range(0, 99);
    if (r < 25) begin
      it = noise_item();
      it.kind = KIND_END;
      if (r < 18) it.frame_index = FrameW'(gen_idx + 1);
      new_take();
    end else if (r < 50) begin
      it = noise_item();
    end else begin
      gen_idx = ($urandom_range(0, 99) == 0) ? $urandom : gen_idx + 1;
      gen_tc = (gen_tc + 1) % TcDay;
      if (p < 4) gen_tc = $urandom_range(0, TcDay - 1);
      else if (p < 7) gen_date = ($urandom_range(0, 1)) ? $urandom : gen_date + 1;
      else if (p < 10) gen_errs = $urandom_range(0, 4095);
      it = frame_at(gen_tc);
      it.frame_index = FrameW'(gen_idx);
      it.date_valid = !gen_nodate;
      it.record_date = gen_nodate ? $urandom : gen_date;
      it.error_blocks = ErrW'(gen_errs);
      if (p >= 10 && p < 13) begin
        it.timecode_valid = 1'b0;
        it.tc_hours = HoursW'($urandom);
        it.tc_minutes = MinutesW'($urandom);
        it.tc_seconds = SecondsW'($urandom);
        it.tc_frames = FramesW'($urandom);
      end else if (p >= 13 && p < 16) begin
        it.date_valid = 1'b0;
        it.record_date = $urandom;
      end
    end
    return it;
  endfunction

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_SKIP_DATE) skip_date_reg = data[0];
    else clip_reg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (frame_beats.size() != 0 || in_valid || segments_due.size() != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic run_phase(logic ign, logic [ClipW-1:0] clip, int count, bit stall, bit calm);
    write_reg(CFG_SKIP_DATE, CfgDataW'(ign));
    write_reg(CFG_CLIP_ID, clip);
    steady = calm;
    if (stall) stall_ticket++;
    new_take();
    repeat (count) add_beat(next_random_item());
    settle();
  endtask

  function automatic item_t directed(int unsigned count, int unsigned idx,
                                     logic [DateW-1:0] date, logic [ErrW-1:0] errs);
    item_t it = frame_at(count);
    it.frame_index = FrameW'(idx);
    it.record_date = date;
    it.error_blocks = errs;
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_SKIP_DATE, CfgDataW'(0));
    write_reg(CFG_CLIP_ID, 8'hFF);
    add_beat(directed(0, 0, 32'h0, 12'h0));
    add_beat(directed(1, 1, 32'h0, 12'h0));
    add_beat(directed(TcDay - 1, 2, 32'h0, 12'h0));
    add_beat(directed(0, 3, 32'h0, 12'h0));
    it = directed(1, 4, 32'h0, 12'h0);
    it.timecode_valid = 1'b0;
    it.tc_hours = '1;
    it.tc_minutes = '1;
    it.tc_seconds = '1;
    it.tc_frames = '1;
    add_beat(it);
    it = directed(2, 5, 32'hFFFF_FFFF, 12'h0);
    it.date_valid = 1'b0;
    add_beat(it);
    add_beat(directed(3, 6, 32'hFFFF_FFFF, 12'h0));
    add_beat(directed(4, 7, 32'hFFFF_FFFF, 12'hFFF));
    it = directed(0, 8, 32'hFFFF_FFFF, 12'hFFF);
    it.tc_hours = '1;
    it.tc_minutes = '1;
    it.tc_seconds = '1;
    it.tc_frames = '1;
    add_beat(it);
    add_beat(directed(100, 20'hFFFFF, 32'h1234_5678, 12'h001));
    it = noise_item();
    it.kind = KIND_END;
    it.frame_index = '0;
    add_beat(it);
    it = noise_item();
    it.kind = KIND_END;
    it.frame_index = FrameW'(5);
    add_beat(it);
    add_beat(directed(500, 0, 32'h8000_0000, 12'h800));
    it = noise_item();
    it.kind = KIND_END;
    it.frame_index = FrameW'(1);
    add_beat(it);
    settle();

    write_reg(CFG_SKIP_DATE, CfgDataW'(1));
    write_reg(CFG_CLIP_ID, 8'h00);
    it = directed(10, 0, 32'hFFFF_FFFF, 12'h0);
    it.date_valid = 1'b0;
    add_beat(it);
    it = directed(11, 1, 32'hFFFF_FFFF, 12'h0);
    it.date_valid = 1'b0;
    add_beat(it);
    add_beat(directed(12, 2, 32'hFFFF_FFFF, 12'h0));
    it = directed(13, 3, 32'hFFFF_FFFF, 12'h0);
    it.timecode_valid = 1'b0;
    add_beat(it);
    add_beat(directed(14, 4, 32'hFFFF_FFFF, 12'h0));
    it = noise_item();
    it.kind = KIND_END;
    it.frame_index = FrameW'(5);
    add_beat(it);
    settle();

    run_phase(1'b0, 8'hFF, 350, 1'b1, 1'b0);
    run_phase(1'b1, 8'h00, 350, 1'b0, 1'b0);
    run_phase(1'b0, ClipW'($urandom), 150, 1'b0, 1'b1);
    run_phase(1'b1, ClipW'($urandom), 350, 1'b0, 1'b0);
    run_phase(1'b0, ClipW'($urandom), 300, 1'b1, 1'b0);
    run_phase(1'b1, 8'hFF, 230, 1'b0, 1'b0);

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
